/* rtl/core/mas_pkg.sv */
// Shared types and constants for the matrix add / subtract / multiply block.
// Used by the controller, the datapath and the top level; no dependencies.
package mas_pkg;

   // Result word format: signed Q24.16 in 40 bits.
   localparam int RES_W = 40;
   // Fraction bits of an input element and the shift that aligns a sum to Q24.16.
   localparam int FRAC_SHIFT = 8;
   // Width of the element field on the request channel.
   localparam int ELEM_PORT_W = 16;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int DIM_REG_W = 4;
   localparam int OP_REG_W = 2;

   localparam logic [2:0] CSR_ROWS_A = 3'd0;
   localparam logic [2:0] CSR_COLS_A = 3'd1;
   localparam logic [2:0] CSR_ROWS_B = 3'd2;
   localparam logic [2:0] CSR_COLS_B = 3'd3;
   localparam logic [2:0] CSR_OPERATION = 3'd4;

   typedef enum logic [1:0] {
      ACT_WRITE_A = 2'd0,
      ACT_WRITE_B = 2'd1,
      ACT_COMPUTE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_DIM_MISMATCH = 2'd1,
      STATUS_NO_OP = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       wr_a;
      logic       wr_b;
      logic       rd_en;
      logic       first;
      logic       last_term;
      logic       op_mul;
      logic       op_sub;
      logic       ld_err;
      status_type err_status;
      logic       res_last;
   } mas_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic out_busy;
      logic elem_done;
   } mas_status_type;

   // Clamp a sum one bit wider than the result to the result range.
   function automatic logic signed [RES_W-1:0] sat_res(input logic signed [RES_W:0] s);
      logic signed [RES_W-1:0] r;
      if (s[RES_W] != s[RES_W-1]) begin
         r = s[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
      end else begin
         r = s[RES_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/mas_ctrl.sv */
// Controller for the matrix block: accepts request words, sequences the row,
// column and inner-product counters and issues commands to mas_datapath. Uses mas_pkg.
module mas_ctrl #(
   parameter int MAX_DIM = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [2:0]                      req_row,
   input  logic [2:0]                      req_col,
   input  logic [mas_pkg::DIM_REG_W-1:0]   rows_a,
   input  logic [mas_pkg::DIM_REG_W-1:0]   cols_a,
   input  logic [mas_pkg::DIM_REG_W-1:0]   rows_b,
   input  logic [mas_pkg::DIM_REG_W-1:0]   cols_b,
   input  logic [mas_pkg::OP_REG_W-1:0]    operation,
   input  mas_pkg::mas_status_type         dp_status,
   output mas_pkg::mas_cmd_type            dp_cmd,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] addr_a,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] addr_b,
   output logic [2:0]                      res_row,
   output logic [2:0]                      res_col
);
   import mas_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_ERR
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     i_ff, i_in;
   logic [IDX_W-1:0]     j_ff, j_in;
   logic [IDX_W-1:0]     x_ff, x_in;
   status_type           err_ff, err_in;

   logic [DIM_W-1:0]     ra, ca, rb, cb;
   logic [IDX_W-1:0]     ra_m1, ca_m1, ncols_m1;
   logic                 op_mul, op_sub;
   logic                 req_accept;
   logic                 in_range;
   logic                 last_term;
   logic [ADDR_W-1:0]    wr_addr;

   // A dimension of zero acts as one; one above MAX_DIM acts as MAX_DIM.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] r);
      logic [DIM_W-1:0] d;
      if (r == '0) begin
         d = DIM_W'(1);
      end else if (32'(r) > MAX_DIM) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(r);
      end
      return d;
   endfunction

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      return ADDR_W'(32'(r) * MAX_DIM + 32'(c));
   endfunction

   assign ra = clamp_dim(rows_a);
   assign ca = clamp_dim(cols_a);
   assign rb = clamp_dim(rows_b);
   assign cb = clamp_dim(cols_b);
   assign ra_m1 = IDX_W'(ra - DIM_W'(1));
   assign ca_m1 = IDX_W'(ca - DIM_W'(1));
   assign op_mul = (operation == OP_MUL);
   assign op_sub = (operation == OP_SUB);
   assign ncols_m1 = op_mul ? IDX_W'(cb - DIM_W'(1)) : ca_m1;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign in_range = (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);
   assign wr_addr = ADDR_W'(32'(req_row) * MAX_DIM + 32'(req_col));
   assign last_term = !op_mul || (x_ff == ca_m1);

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      x_in = x_ff;
      err_in = err_ff;
      dp_cmd = '0;
      dp_cmd.err_status = STATUS_OK;
      dp_cmd.res_last = (i_ff == ra_m1) && (j_ff == ncols_m1);
      addr_a = '0;
      addr_b = '0;
      res_row = 3'(i_ff);
      res_col = 3'(j_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_action)
                  ACT_WRITE_A: begin
                     dp_cmd.wr_a = in_range;
                     addr_a = wr_addr;
                  end
                  ACT_WRITE_B: begin
                     dp_cmd.wr_b = in_range;
                     addr_b = wr_addr;
                  end
                  ACT_COMPUTE: begin
                     i_in = '0;
                     j_in = '0;
                     x_in = '0;
                     if (op_mul) begin
                        if (ca != rb) begin
                           err_in = STATUS_DIM_MISMATCH;
                           state_in = ST_ERR;
                        end else begin
                           state_in = ST_ISSUE;
                        end
                     end else if (ra != rb || ca != cb) begin
                        err_in = STATUS_DIM_MISMATCH;
                        state_in = ST_ERR;
                     end else if (operation == OP_NONE) begin
                        err_in = STATUS_NO_OP;
                        state_in = ST_ERR;
                     end else begin
                        state_in = ST_ISSUE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            // The first read of an element waits until the output word is free.
            if (!(x_ff == '0 && dp_status.out_busy)) begin
               dp_cmd.rd_en = 1'b1;
               dp_cmd.first = (x_ff == '0);
               dp_cmd.last_term = last_term;
               dp_cmd.op_mul = op_mul;
               dp_cmd.op_sub = op_sub;
               if (op_mul) begin
                  addr_a = elem_addr(i_ff, x_ff);
                  addr_b = elem_addr(x_ff, j_ff);
               end else begin
                  addr_a = elem_addr(i_ff, j_ff);
                  addr_b = elem_addr(i_ff, j_ff);
               end
               if (last_term) begin
                  state_in = ST_DRAIN;
               end else begin
                  x_in = x_ff + IDX_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (dp_status.elem_done) begin
               x_in = '0;
               if (j_ff == ncols_m1) begin
                  j_in = '0;
                  if (i_ff == ra_m1) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                     state_in = ST_ISSUE;
                  end
               end else begin
                  j_in = j_ff + IDX_W'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ERR: begin
            res_row = '0;
            res_col = '0;
            if (!dp_status.out_busy) begin
               dp_cmd.ld_err = 1'b1;
               dp_cmd.err_status = err_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff <= '0;
         j_ff <= '0;
         x_ff <= '0;
         err_ff <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         j_ff <= j_in;
         x_ff <= x_in;
         err_ff <= err_in;
      end
   end

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      dp_status.elem_done |-> state_ff == ST_DRAIN)
      else $error("datapath finished an element outside the drain state");

   a_compute_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action == ACT_COMPUTE) |=> req_stall)
      else $error("compute word did not stall the request channel");

endmodule

/* rtl/core/mas_datapath.sv */
// Datapath for the matrix block: the A and B element stores, the
// read / multiply / accumulate pipeline and the result word register. Uses mas_pkg.
module mas_datapath #(
   parameter int MAX_DIM = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mas_pkg::mas_cmd_type                dp_cmd,
   output mas_pkg::mas_status_type             dp_status,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  addr_a,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  addr_b,
   input  logic [2:0]                          res_row,
   input  logic [2:0]                          res_col,
   input  logic signed [mas_pkg::ELEM_PORT_W-1:0] wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [mas_pkg::RES_W-1:0]    rsp_result_value,
   output logic [2:0]                          rsp_result_row,
   output logic [2:0]                          rsp_result_col,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last
);
   import mas_pkg::*;

   localparam int STORE_W = (ELEM_WIDTH < ELEM_PORT_W) ? ELEM_WIDTH : ELEM_PORT_W;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int PROD_W = 2 * STORE_W;
   localparam int SUM_W = STORE_W + 1 + FRAC_SHIFT;

   // Element stores; the valid bits make never-written entries read as zero.
   logic [STORE_W-1:0]  mem_a [DEPTH];
   logic [STORE_W-1:0]  mem_b [DEPTH];
   logic [DEPTH-1:0]    valid_a_ff, valid_a_in;
   logic [DEPTH-1:0]    valid_b_ff, valid_b_in;
   logic [STORE_W-1:0]  rd_a_ff, rd_b_ff;

   // Read stage.
   logic                s1_valid_ff, s1_first_ff, s1_last_ff, s1_mul_ff, s1_sub_ff;
   logic                va_ff, vb_ff;
   // Product stage.
   logic                s2_valid_ff, s2_first_ff, s2_last_ff;
   logic signed [RES_W-1:0] term_ff, term_in;
   // Accumulator and result word.
   logic signed [RES_W-1:0] acc_ff, acc_in;
   logic signed [RES_W:0]   acc_sum;
   logic                out_valid_ff, out_valid_in;
   logic signed [RES_W-1:0] out_value_ff, out_value_in;
   logic [2:0]          out_row_ff, out_row_in;
   logic [2:0]          out_col_ff, out_col_in;
   status_type          out_status_ff, out_status_in;
   logic                out_last_ff, out_last_in;

   logic signed [STORE_W-1:0] a_val, b_val;
   logic signed [PROD_W-1:0]  prod;
   logic signed [STORE_W:0]   lin;
   logic signed [SUM_W-1:0]   lin_shift;
   logic                      load_elem;

   always_ff @(posedge clock) begin
      if (dp_cmd.wr_a) begin
         mem_a[addr_a] <= wr_data[STORE_W-1:0];
      end
      if (dp_cmd.wr_b) begin
         mem_b[addr_b] <= wr_data[STORE_W-1:0];
      end
      rd_a_ff <= mem_a[addr_a];
      rd_b_ff <= mem_b[addr_b];
   end

   always_comb begin
      valid_a_in = valid_a_ff;
      valid_b_in = valid_b_ff;
      if (dp_cmd.wr_a) begin
         valid_a_in[addr_a] = 1'b1;
      end
      if (dp_cmd.wr_b) begin
         valid_b_in[addr_b] = 1'b1;
      end
   end

   // Term for the product stage: a product, or a sum or difference moved to Q24.16.
   assign a_val = va_ff ? $signed(rd_a_ff) : '0;
   assign b_val = vb_ff ? $signed(rd_b_ff) : '0;
   assign prod = a_val * b_val;
   assign lin = s1_sub_ff ? ({a_val[STORE_W-1], a_val} - {b_val[STORE_W-1], b_val})
                          : ({a_val[STORE_W-1], a_val} + {b_val[STORE_W-1], b_val});
   assign lin_shift = {lin, {FRAC_SHIFT{1'b0}}};
   assign term_in = s1_mul_ff ? {{(RES_W-PROD_W){prod[PROD_W-1]}}, prod}
                              : {{(RES_W-SUM_W){lin_shift[SUM_W-1]}}, lin_shift};

   assign acc_sum = {acc_ff[RES_W-1], acc_ff} + {term_ff[RES_W-1], term_ff};
   assign acc_in = s2_first_ff ? term_ff : sat_res(acc_sum);
   assign load_elem = s2_valid_ff && s2_last_ff;

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      out_status_in = out_status_ff;
      out_last_in = out_last_ff;
      if (load_elem) begin
         out_valid_in = 1'b1;
         out_value_in = acc_in;
         out_row_in = res_row;
         out_col_in = res_col;
         out_status_in = STATUS_OK;
         out_last_in = dp_cmd.res_last;
      end else if (dp_cmd.ld_err) begin
         out_valid_in = 1'b1;
         out_value_in = '0;
         out_row_in = res_row;
         out_col_in = res_col;
         out_status_in = dp_cmd.err_status;
         out_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= '0;
         valid_b_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         s1_valid_ff <= dp_cmd.rd_en;
         s2_valid_ff <= s1_valid_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= dp_cmd.first;
      s1_last_ff <= dp_cmd.last_term;
      s1_mul_ff <= dp_cmd.op_mul;
      s1_sub_ff <= dp_cmd.op_sub;
      va_ff <= valid_a_ff[addr_a];
      vb_ff <= valid_b_ff[addr_b];
      s2_first_ff <= s1_first_ff;
      s2_last_ff <= s1_last_ff;
      term_ff <= term_in;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      out_value_ff <= out_value_in;
      out_row_ff <= out_row_in;
      out_col_ff <= out_col_in;
      out_status_ff <= out_status_in;
      out_last_ff <= out_last_in;
   end

   assign dp_status.out_busy = out_valid_ff;
   assign dp_status.elem_done = load_elem;

   assign rsp_valid = out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_result_row = out_row_ff;
   assign rsp_result_col = out_col_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last = out_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (load_elem || dp_cmd.ld_err) |-> !out_valid_ff)
      else $error("result word loaded while the previous one still waits");

   a_elem_reaches_output: assert property (@(posedge clock) disable iff (reset)
      load_elem |=> rsp_valid)
      else $error("finished element did not appear on the result channel");

endmodule

/* rtl/core/matrix_add_sub_multiply.sv */
// Top level of the matrix add / subtract / multiply block: configuration
// registers and the link between mas_ctrl and mas_datapath. Uses mas_pkg.
//
//   Channel  Direction  Handshake                  Word
//   req_     in         req_valid / req_stall      action, row, col, element
//   rsp_     out        rsp_valid / rsp_stall      result value, row, col, status, last
//   csr_     in/out     APB psel/penable, pready=1 rows_a, cols_a, rows_b, cols_b, operation
//
// An element write does not stall the request channel; the next request word is taken in
// the following cycle. A compute word stalls the request channel until its last result is
// loaded. A multiply reads cols_a terms for each result and an add or subtract reads one,
// through the single read port of each store and the read, multiply and accumulate stages;
// a result's reads start only after the previous result is loaded. Reset is synchronous;
// the stores read as zero after reset through per-entry valid bits, so no clearing pass is
// needed. A stalled result channel holds the controller before the next element starts.
module matrix_add_sub_multiply #(
   parameter int MAX_DIM = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_action,
   input  logic [2:0]                            req_row,
   input  logic [2:0]                            req_col,
   input  logic signed [mas_pkg::ELEM_PORT_W-1:0] req_element,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mas_pkg::RES_W-1:0]      rsp_result_value,
   output logic [2:0]                            rsp_result_row,
   output logic [2:0]                            rsp_result_col,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_last,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mas_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [mas_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [mas_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import mas_pkg::*;

   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   logic [DIM_REG_W-1:0] rows_a_ff, rows_a_in;
   logic [DIM_REG_W-1:0] cols_a_ff, cols_a_in;
   logic [DIM_REG_W-1:0] rows_b_ff, rows_b_in;
   logic [DIM_REG_W-1:0] cols_b_ff, cols_b_in;
   logic [OP_REG_W-1:0]  op_ff, op_in;
   logic                 csr_write;
   logic [2:0]           csr_index;

   mas_cmd_type          dp_cmd;
   mas_status_type       dp_status;
   logic [ADDR_W-1:0]    addr_a, addr_b;
   logic [2:0]           res_row, res_col;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = csr_paddr[4:2];

   always_comb begin
      rows_a_in = rows_a_ff;
      cols_a_in = cols_a_ff;
      rows_b_in = rows_b_ff;
      cols_b_in = cols_b_ff;
      op_in = op_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ROWS_A: rows_a_in = csr_pwdata[DIM_REG_W-1:0];
            CSR_COLS_A: cols_a_in = csr_pwdata[DIM_REG_W-1:0];
            CSR_ROWS_B: rows_b_in = csr_pwdata[DIM_REG_W-1:0];
            CSR_COLS_B: cols_b_in = csr_pwdata[DIM_REG_W-1:0];
            CSR_OPERATION: op_in = csr_pwdata[OP_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_ROWS_A: csr_prdata = CSR_DATA_W'(rows_a_ff);
         CSR_COLS_A: csr_prdata = CSR_DATA_W'(cols_a_ff);
         CSR_ROWS_B: csr_prdata = CSR_DATA_W'(rows_b_ff);
         CSR_COLS_B: csr_prdata = CSR_DATA_W'(cols_b_ff);
         CSR_OPERATION: csr_prdata = CSR_DATA_W'(op_ff);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= DIM_REG_W'(1);
         cols_a_ff <= DIM_REG_W'(1);
         rows_b_ff <= DIM_REG_W'(1);
         cols_b_ff <= DIM_REG_W'(1);
         op_ff <= OP_ADD;
      end else begin
         rows_a_ff <= rows_a_in;
         cols_a_ff <= cols_a_in;
         rows_b_ff <= rows_b_in;
         cols_b_ff <= cols_b_in;
         op_ff <= op_in;
      end
   end

   mas_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_row    (req_row),
      .req_col    (req_col),
      .rows_a     (rows_a_ff),
      .cols_a     (cols_a_ff),
      .rows_b     (rows_b_ff),
      .cols_b     (cols_b_ff),
      .operation  (op_ff),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd),
      .addr_a     (addr_a),
      .addr_b     (addr_b),
      .res_row    (res_row),
      .res_col    (res_col)
   );

   mas_datapath #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .addr_a           (addr_a),
      .addr_b           (addr_b),
      .res_row          (res_row),
      .res_col          (res_col),
      .wr_data          (req_element),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_result_row   (rsp_result_row),
      .rsp_result_col   (rsp_result_col),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule
